[rtl/core/spsq_pkg.sv]
// ----------------------------------------------------------------------------
// spsq_pkg - stepper phase sequencer package
// Widths, operation and mode codes, and the coil pattern tables.
// ----------------------------------------------------------------------------
package spsq_pkg;

    localparam int COUNT_WIDTH  = 20;
    localparam int PERIOD_WIDTH = 16;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ROTATE = 2'd1;
    localparam logic [1:0] OP_RUN    = 2'd2;
    localparam logic [1:0] OP_STOP   = 2'd3;

    localparam logic [1:0] MODE_WAVE = 2'd0;
    localparam logic [1:0] MODE_FULL = 2'd1;
    localparam logic [1:0] MODE_HALF = 2'd2;

    localparam logic [3:0] WAVE_CW  [4] = '{4'h8, 4'h4, 4'h2, 4'h1};
    localparam logic [3:0] WAVE_CCW [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
    localparam logic [3:0] FULL_CW  [4] = '{4'hc, 4'h6, 4'h3, 4'h9};
    localparam logic [3:0] FULL_CCW [4] = '{4'h9, 4'h3, 4'h6, 4'hc};
    localparam logic [3:0] HALF_CW  [8] = '{4'h8, 4'hc, 4'h4, 4'h6,
                                            4'h2, 4'h3, 4'h1, 4'h9};
    localparam logic [3:0] HALF_CCW [8] = '{4'h1, 4'h3, 4'h2, 4'h6,
                                            4'h4, 4'hc, 4'h8, 4'h9};

    function automatic logic [3:0] beat_pattern(
        input logic [1:0] mode,
        input logic       dir,
        input logic [2:0] idx
    );
        logic [3:0] pat;
        unique case (mode)
            MODE_FULL: pat = dir ? FULL_CCW[idx[1:0]] : FULL_CW[idx[1:0]];
            MODE_HALF: pat = dir ? HALF_CCW[idx] : HALF_CW[idx];
            default:   pat = dir ? WAVE_CCW[idx[1:0]] : WAVE_CW[idx[1:0]];
        endcase
        return pat;
    endfunction

endpackage

[rtl/core/spsq_if.sv]
// ----------------------------------------------------------------------------
// spsq_if - stepper phase sequencer channels
// Command channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface spsq_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       op;
    logic                             direction;
    logic [spsq_pkg::COUNT_WIDTH-1:0]  step_count;
    logic [spsq_pkg::PERIOD_WIDTH-1:0] period_ticks;

    modport source (output valid, output op, output direction, output step_count,
                    output period_ticks, input ready);
    modport sink   (input valid, input op, input direction, input step_count,
                    input period_ticks, output ready);
endinterface

interface spsq_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] coils;
    logic       busy_res;
    logic       beat_emitted;

    modport source (output valid, output coils, output busy_res, output beat_emitted,
                    input ready);
    modport sink   (input valid, input coils, input busy_res, input beat_emitted,
                    output ready);
endinterface

[rtl/core/stepper_phase_sequencer.sv]
// ----------------------------------------------------------------------------
// stepper_phase_sequencer - four-coil unipolar stepper sequencer
// Tick and command transfers drive wave, full step or half step coil patterns.
// ----------------------------------------------------------------------------
// One command or tick transfer is taken every clock cycle; its result appears
// in the output register on the following cycle. The input stalls only while
// that register holds a result the sink has not taken. The rate is set by the
// single state update path (period counter, step counter, pattern table)
// feeding the output register.
module stepper_phase_sequencer (
    input  logic                             clk,
    input  logic                             rst_n,
    spsq_cmd_if.sink                         in_ch,
    spsq_res_if.source                       out_ch,
    input  logic                             cfg_wr_en,
    input  logic [1:0]                       cfg_wr_data
);
    import spsq_pkg::*;

    logic [1:0]              mode_reg;
    logic [2:0]              beat_index_reg, beat_index_next;
    logic [COUNT_WIDTH-1:0]  steps_left_reg, steps_left_next;
    logic [PERIOD_WIDTH-1:0] beat_period_reg, beat_period_next;
    logic [PERIOD_WIDTH-1:0] tick_count_reg, tick_count_next;
    logic                    dir_reg, dir_next;
    logic                    continuous_reg, continuous_next;
    logic                    running_reg, running_next;
    logic [3:0]              coil_reg, coil_next;
    logic                    beat_next;

    logic                    out_valid_reg;
    logic                    out_busy_reg;
    logic                    out_beat_reg;

    logic                    take;
    logic                    busy_now;
    logic [PERIOD_WIDTH-1:0] tick_inc;
    logic [PERIOD_WIDTH-1:0] per_eff;
    logic [2:0]              idx_eff;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign take        = in_ch.valid && in_ch.ready;
    assign busy_now    = (steps_left_reg != '0) || continuous_reg;

    assign tick_inc = tick_count_reg + PERIOD_WIDTH'(1);
    assign per_eff  = (in_ch.period_ticks == '0) ? PERIOD_WIDTH'(1) : in_ch.period_ticks;
    assign idx_eff  = ((mode_reg != MODE_HALF) && beat_index_reg[2]) ? 3'd0 : beat_index_reg;

    always_comb
    begin
        beat_index_next  = beat_index_reg;
        steps_left_next  = steps_left_reg;
        beat_period_next = beat_period_reg;
        tick_count_next  = tick_count_reg;
        dir_next         = dir_reg;
        continuous_next  = continuous_reg;
        running_next     = running_reg;
        coil_next        = coil_reg;
        beat_next        = 1'b0;
        unique case (in_ch.op)
            OP_TICK:
            begin
                if (running_reg)
                begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= beat_period_reg)
                    begin
                        tick_count_next = '0;
                        if (continuous_reg || (steps_left_reg != '0))
                        begin
                            if (!continuous_reg)
                                steps_left_next = steps_left_reg - COUNT_WIDTH'(1);
                            coil_next       = beat_pattern(mode_reg, dir_reg, idx_eff);
                            beat_index_next = idx_eff + 3'd1;
                            beat_next       = 1'b1;
                        end
                        else
                        begin
                            steps_left_next  = '0;
                            continuous_next  = 1'b0;
                            running_next     = 1'b0;
                            beat_period_next = '0;
                            coil_next        = 4'h0;
                        end
                    end
                end
            end
            OP_STOP:
            begin
                steps_left_next  = '0;
                continuous_next  = 1'b0;
                running_next     = 1'b0;
                beat_period_next = '0;
                tick_count_next  = '0;
                coil_next        = 4'h0;
            end
            default:
            begin
                tick_count_next  = '0;
                coil_next        = 4'h0;
                dir_next         = in_ch.direction;
                beat_period_next = per_eff;
                running_next     = 1'b1;
                steps_left_next  = (in_ch.op == OP_ROTATE) ? in_ch.step_count : '0;
                continuous_next  = (in_ch.op == OP_RUN);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_WAVE;
            beat_index_reg  <= '0;
            steps_left_reg  <= '0;
            beat_period_reg <= '0;
            tick_count_reg  <= '0;
            dir_reg         <= 1'b0;
            continuous_reg  <= 1'b0;
            running_reg     <= 1'b0;
            coil_reg        <= 4'h0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en && (cfg_wr_data <= MODE_HALF) && !busy_now)
                mode_reg <= cfg_wr_data;
            if (take)
            begin
                beat_index_reg  <= beat_index_next;
                steps_left_reg  <= steps_left_next;
                beat_period_reg <= beat_period_next;
                tick_count_reg  <= tick_count_next;
                dir_reg         <= dir_next;
                continuous_reg  <= continuous_next;
                running_reg     <= running_next;
                coil_reg        <= coil_next;
            end
            if (take)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, coils come straight from coil_reg
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_busy_reg <= (steps_left_next != '0) || continuous_next;
            out_beat_reg <= beat_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.coils        = coil_reg;
    assign out_ch.busy_res     = out_busy_reg;
    assign out_ch.beat_emitted = out_beat_reg;

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb - stepper phase sequencer testbench
// Feeds tick and command transfers with random gaps and mode writes between
// phases. A local model of the coil sequencer predicts each result, and the
// result stream is checked field by field while the sink stalls at random.
// ----------------------------------------------------------------------------
module tb;
    import spsq_pkg::*;

    typedef struct packed {
        logic                    is_cfg;
        logic [1:0]              mode;
        logic [1:0]              op;
        logic                    dir;
        logic [COUNT_WIDTH-1:0]  cnt;
        logic [PERIOD_WIDTH-1:0] per;
    } cmd_item_t;

    typedef struct packed {
        logic [3:0] coils;
        logic       busy;
        logic       beat;
    } coil_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       cmd_valid = 1'b0;
    cmd_item_t  cmd_cur = '0;
    logic       res_ready = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_wr_data = MODE_WAVE;

    spsq_cmd_if cmd ();
    spsq_res_if res ();

    assign cmd.valid        = cmd_valid;
    assign cmd.op           = cmd_cur.op;
    assign cmd.direction    = cmd_cur.dir;
    assign cmd.step_count   = cmd_cur.cnt;
    assign cmd.period_ticks = cmd_cur.per;
    assign res.ready        = res_ready;

    stepper_phase_sequencer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (cmd),
        .out_ch      (res),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 clk = ~clk;

    // sequencer model state
    logic [1:0]              exc_mode   = MODE_WAVE;
    logic [2:0]              ph_idx     = '0;
    logic [COUNT_WIDTH-1:0]  beats_left = '0;
    logic [PERIOD_WIDTH-1:0] period_lat = '0;
    logic [PERIOD_WIDTH-1:0] tick_acc   = '0;
    logic                    dir_lat    = 1'b0;
    logic                    cont_mode  = 1'b0;
    logic                    run_flag   = 1'b0;
    logic [3:0]              coil_state = '0;

    cmd_item_t   pending_q [$];
    coil_res_t   coil_exp_q [$];
    int unsigned n_items = 0;
    int unsigned n_fail = 0;

    int unsigned send_gap = 0;
    int unsigned send_calm = 0;
    int unsigned sink_gap = 0;
    int unsigned sink_calm = 0;
    int unsigned cyc_cnt = 0;
    logic        hold_off = 1'b0;

    function automatic int unsigned pause_len(inout int unsigned calm);
        if (calm != 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm = $urandom_range(10, 60);
        return $urandom_range(0, 17);
    endfunction

    function automatic logic [3:0] coil_pattern(input logic [1:0] mode, input logic dir,
                                                input logic [2:0] idx);
        logic [3:0] p;
        p = 4'h0;
        if (mode == MODE_HALF)
        begin
            case ({dir, idx})
                4'd0:  p = 4'h8;
                4'd1:  p = 4'hc;
                4'd2:  p = 4'h4;
                4'd3:  p = 4'h6;
                4'd4:  p = 4'h2;
                4'd5:  p = 4'h3;
                4'd6:  p = 4'h1;
                4'd7:  p = 4'h9;
                4'd8:  p = 4'h1;
                4'd9:  p = 4'h3;
                4'd10: p = 4'h2;
                4'd11: p = 4'h6;
                4'd12: p = 4'h4;
                4'd13: p = 4'hc;
                4'd14: p = 4'h8;
                default: p = 4'h9;
            endcase
        end
        else if (mode == MODE_FULL)
        begin
            case ({dir, idx[1:0]})
                3'd0: p = 4'hc;
                3'd1: p = 4'h6;
                3'd2: p = 4'h3;
                3'd3: p = 4'h9;
                3'd4: p = 4'h9;
                3'd5: p = 4'h3;
                3'd6: p = 4'h6;
                default: p = 4'hc;
            endcase
        end
        else
        begin
            case ({dir, idx[1:0]})
                3'd0: p = 4'h8;
                3'd1: p = 4'h4;
                3'd2: p = 4'h2;
                3'd3: p = 4'h1;
                3'd4: p = 4'h1;
                3'd5: p = 4'h2;
                3'd6: p = 4'h4;
                default: p = 4'h8;
            endcase
        end
        return p;
    endfunction

    function automatic void coils_off();
        beats_left = '0;
        cont_mode  = 1'b0;
        run_flag   = 1'b0;
        period_lat = '0;
        tick_acc   = '0;
        coil_state = '0;
    endfunction

    function automatic void next_beat();
        logic [3:0] len;
        len = (exc_mode == MODE_HALF) ? 4'd8 : 4'd4;
        if ({1'b0, ph_idx} >= len)
            ph_idx = '0;
        coil_state = coil_pattern(exc_mode, dir_lat, ph_idx);
        ph_idx = ph_idx + 3'd1;
    endfunction

    function automatic coil_res_t sequence_step(input cmd_item_t it);
        coil_res_t               r;
        logic [PERIOD_WIDTH-1:0] per;
        logic                    beat;
        beat = 1'b0;
        per = (it.per == '0) ? PERIOD_WIDTH'(1) : it.per;
        case (it.op)
            OP_TICK:
            begin
                if (run_flag)
                begin
                    tick_acc = tick_acc + 1'b1;
                    if (tick_acc >= period_lat)
                    begin
                        tick_acc = '0;
                        if (cont_mode)
                        begin
                            next_beat();
                            beat = 1'b1;
                        end
                        else if (beats_left != '0)
                        begin
                            beats_left = beats_left - 1'b1;
                            next_beat();
                            beat = 1'b1;
                        end
                        else
                            coils_off();
                    end
                end
            end
            OP_STOP:
                coils_off();
            default:
            begin
                coils_off();
                dir_lat    = it.dir;
                period_lat = per;
                run_flag   = 1'b1;
                if (it.op == OP_ROTATE)
                    beats_left = it.cnt;
                else
                    cont_mode = 1'b1;
            end
        endcase
        r.coils = coil_state;
        r.busy  = (beats_left != '0) || cont_mode;
        r.beat  = beat;
        return r;
    endfunction

    task automatic queue_cmd(input logic [1:0] op, input int unsigned dir,
                             input int unsigned cnt, input int unsigned per);
        cmd_item_t it;
        it = '0;
        it.op  = op;
        it.dir = dir[0];
        it.cnt = cnt[COUNT_WIDTH-1:0];
        it.per = per[PERIOD_WIDTH-1:0];
        pending_q.push_back(it);
        n_items++;
    endtask

    task automatic queue_mode(input logic [1:0] m);
        cmd_item_t it;
        it = '0;
        it.is_cfg = 1'b1;
        it.mode   = m;
        pending_q.push_back(it);
    endtask

    task automatic queue_tick();
        queue_cmd(OP_TICK, $urandom, $urandom, $urandom);
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin : drive_cmds
        logic       v_nxt;
        cmd_item_t  c_nxt;
        logic       w_nxt;
        logic [1:0] d_nxt;
        if (!rst_n)
        begin
            cmd_valid   <= 1'b0;
            cmd_cur     <= '0;
            cfg_wr_en   <= 1'b0;
            cfg_wr_data <= MODE_WAVE;
            send_gap = 0;
        end
        else
        begin
            v_nxt = cmd_valid;
            c_nxt = cmd_cur;
            w_nxt = 1'b0;
            d_nxt = cfg_wr_data;
            if (cmd_valid && cmd.ready)
            begin
                coil_exp_q.push_back(sequence_step(cmd_cur));
                v_nxt = 1'b0;
                send_gap = pause_len(send_calm);
            end
            if (!v_nxt)
            begin
                if (send_gap != 0)
                    send_gap--;
                else if (pending_q.size() != 0)
                begin
                    if (!pending_q[0].is_cfg)
                    begin
                        c_nxt = pending_q.pop_front();
                        v_nxt = 1'b1;
                    end
                    else if (coil_exp_q.size() == 0)
                    begin
                        // mode writes land only while no transfer is in flight
                        d_nxt = pending_q[0].mode;
                        w_nxt = 1'b1;
                        if (d_nxt <= MODE_HALF && beats_left == '0 && !cont_mode)
                            exc_mode = d_nxt;
                        pending_q.delete(0);
                        send_gap = pause_len(send_calm);
                    end
                end
            end
            cmd_valid   <= v_nxt;
            cmd_cur     <= c_nxt;
            cfg_wr_en   <= w_nxt;
            cfg_wr_data <= d_nxt;
        end
    end

    // long sink hold-off windows
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyc_cnt  <= 0;
            hold_off <= 1'b0;
        end
        else
        begin
            cyc_cnt  <= cyc_cnt + 1;
            hold_off <= (cyc_cnt >= 1500 && cyc_cnt < 1800) ||
                        (cyc_cnt >= 5000 && cyc_cnt < 5400);
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : watch_results
        coil_res_t want;
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (res.valid && res_ready)
            begin
                if (coil_exp_q.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    n_fail++;
                end
                else
                begin
                    want = coil_exp_q.pop_front();
                    if (res.coils !== want.coils)
                    begin
                        $error("coils: expected %0h, got %0h", want.coils, res.coils);
                        n_fail++;
                    end
                    if (res.busy_res !== want.busy)
                    begin
                        $error("busy_res: expected %0d, got %0d", want.busy, res.busy_res);
                        n_fail++;
                    end
                    if (res.beat_emitted !== want.beat)
                    begin
                        $error("beat_emitted: expected %0d, got %0d", want.beat,
                               res.beat_emitted);
                        n_fail++;
                    end
                end
                sink_gap = pause_len(sink_calm);
            end
            else if (sink_gap != 0)
                sink_gap--;
            res_ready <= (sink_gap == 0) && !hold_off;
        end
    end

    initial
    begin
        #3000000;
        $display("FAIL stepper_phase_sequencer");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned r;
        int unsigned op_sel;
        int unsigned cnt;
        int unsigned per;
        int unsigned k;

        // directed
        queue_mode(MODE_WAVE);
        queue_cmd(OP_TICK, 0, 0, 0);
        queue_cmd(OP_ROTATE, 0, 3, 0);
        repeat (5) queue_cmd(OP_TICK, 0, 0, 0);
        queue_mode(MODE_FULL);
        queue_cmd(OP_ROTATE, 1, 2, 2);
        repeat (5) queue_cmd(OP_TICK, 0, 0, 0);
        queue_mode(MODE_HALF);
        queue_cmd(OP_RUN, 1, 0, 1);
        repeat (3) queue_cmd(OP_TICK, 0, 0, 0);
        queue_cmd(OP_ROTATE, 0, 0, 1);
        repeat (2) queue_cmd(OP_TICK, 0, 0, 0);
        queue_cmd(OP_ROTATE, 1, 32'hfffff, 32'hffff);
        queue_cmd(OP_TICK, 1, 32'hfffff, 32'hffff);
        queue_mode(MODE_WAVE);
        queue_cmd(OP_STOP, 1, 32'hfffff, 32'hffff);
        queue_mode(2'd3);
        queue_cmd(OP_RUN, 0, 0, 1);
        repeat (2) queue_cmd(OP_TICK, 0, 0, 0);

        // random
        while (n_items < 1350)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    queue_cmd(OP_STOP, $urandom, $urandom, $urandom);
                queue_mode(2'($urandom_range(0, 3)));
            end
            r = $urandom_range(0, 15);
            if (r < 12)
            begin
                op_sel = $urandom_range(0, 2);
                cnt = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 9);
                per = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4);
                queue_cmd((op_sel == 2) ? OP_RUN : OP_ROTATE, $urandom, cnt, per);
                k = $urandom_range(0, 40);
                repeat (k) queue_tick();
                if ($urandom_range(0, 3) == 0)
                    queue_cmd(OP_STOP, $urandom, $urandom, $urandom);
            end
            else
            begin
                k = $urandom_range(1, 5);
                repeat (k) queue_cmd(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (pending_q.size() != 0 || cmd_valid || coil_exp_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (n_fail == 0 && coil_exp_q.size() == 0)
            $display("PASS stepper_phase_sequencer");
        else
            $display("FAIL stepper_phase_sequencer");
        $finish;
    end

endmodule
